@@ hw/rtl/hiwa_pkg.sv @@
// shared register map for the homography inverse warp address block
package hiwa_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROW0_XY   = 3'd0,
    CFG_ROW0C_R1X = 3'd1,
    CFG_ROW1_YC   = 3'd2,
    CFG_ROW2_XY   = 3'd3,
    CFG_ROW2_C    = 3'd4,
    CFG_SRC_W     = 3'd5,
    CFG_SRC_H     = 3'd6,
    CFG_OUT_H     = 3'd7
  } cfg_idx_e;

  localparam int unsigned SizeBits = 13;
  localparam logic [SizeBits-1:0] SizeReset = 13'd4096;

endpackage

@@ hw/rtl/homography_inverse_warp_addr.sv @@
// top level: projective inverse mapping to nearest source pixel address
// One beat in and one beat out per clock when the output is not stalled. The stages are
// coordinate setup, six parallel 32-bit coefficient products, the three sums, sign
// normalization, then a pipelined divider per axis that resolves one quotient bit per
// stage (plus one range stage), and at the end a final range check and an output
// register. The quotients carry 13 bits or more so that source heights above 4096 still
// resolve every row. The whole pipeline holds while the output beat is stalled. Write the
// configuration registers only while no beat is in flight.
module homography_inverse_warp_addr
  import hiwa_pkg::*;
#(
  parameter int unsigned COORD_BITS     = 12,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] out_row_i,
  input  logic [COORD_BITS-1:0] out_col_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] src_row_o,
  output logic [COORD_BITS-1:0] src_col_o,
  output logic                  inside_res_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned MB   = (CB > SizeBits) ? CB : SizeBits;
  localparam int unsigned PW   = MB + 3;
  localparam int unsigned PRW  = PW + 32;
  localparam int unsigned SUMW = PW + 34;
  localparam int unsigned SW   = PW + 36;
  localparam int unsigned LW   = MB + 2;
  localparam logic [63:0] CoefOne = 64'd1 << (32 + COEF_FRAC_BITS);
  localparam logic [31:0] H22One  = 32'd1 << COEF_FRAC_BITS;

  // configuration registers
  logic [63:0]         c0_q, c1_q, c2_q, c3_q;
  logic [31:0]         c4_q;
  logic [SizeBits-1:0] sw_q, sh_q, oh_q;
  logic                wr_en;
  cfg_idx_e            widx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign widx   = cfg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= CoefOne;
      c1_q <= '0;
      c2_q <= CoefOne;
      c3_q <= '0;
      c4_q <= H22One;
      sw_q <= SizeReset;
      sh_q <= SizeReset;
      oh_q <= SizeReset;
    end else if (wr_en) begin
      unique case (widx)
        CFG_ROW0_XY:   c0_q <= pwdata;
        CFG_ROW0C_R1X: c1_q <= pwdata;
        CFG_ROW1_YC:   c2_q <= pwdata;
        CFG_ROW2_XY:   c3_q <= pwdata;
        CFG_ROW2_C:    c4_q <= pwdata[31:0];
        CFG_SRC_W:     sw_q <= pwdata[SizeBits-1:0];
        CFG_SRC_H:     sh_q <= pwdata[SizeBits-1:0];
        CFG_OUT_H:     oh_q <= pwdata[SizeBits-1:0];
        default:       c0_q <= c0_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (widx)
      CFG_ROW0_XY:   prdata = c0_q;
      CFG_ROW0C_R1X: prdata = c1_q;
      CFG_ROW1_YC:   prdata = c2_q;
      CFG_ROW2_XY:   prdata = c3_q;
      CFG_ROW2_C:    prdata = {32'd0, c4_q};
      CFG_SRC_W:     prdata = {{(64-SizeBits){1'b0}}, sw_q};
      CFG_SRC_H:     prdata = {{(64-SizeBits){1'b0}}, sh_q};
      CFG_OUT_H:     prdata = {{(64-SizeBits){1'b0}}, oh_q};
      default:       prdata = '0;
    endcase
  end

  // pipeline advance: hold everything while the output beat is stalled
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic v0_q, v1_q, v2_q, v3_q;
  logic vd_q [MB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      for (int i = 0; i <= MB; i++) vd_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vd_q[0]     <= v3_q;
      for (int i = 1; i <= MB; i++) vd_q[i] <= vd_q[i-1];
      out_valid_q <= vd_q[MB];
    end
  end

  // stage 0: half-pixel coordinates 2x and 2y
  logic signed [PW-1:0] x2_q, y2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q <= PW'($signed({{(PW-CB){1'b0}}, out_col_i}) * 2 - PW'(1));
      y2_q <= PW'(($signed({{(PW-SizeBits){1'b0}}, oh_q}) -
                   $signed({{(PW-CB){1'b0}}, out_row_i})) * 2 + PW'(1));
    end
  end

  // stage 1: coefficient products
  logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  assign h00 = $signed(c0_q[63:32]);
  assign h01 = $signed(c0_q[31:0]);
  assign h02 = $signed(c1_q[63:32]);
  assign h10 = $signed(c1_q[31:0]);
  assign h11 = $signed(c2_q[63:32]);
  assign h12 = $signed(c2_q[31:0]);
  assign h20 = $signed(c3_q[63:32]);
  assign h21 = $signed(c3_q[31:0]);
  assign h22 = $signed(c4_q);

  logic signed [PRW-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q <= h00 * x2_q;
      p01_q <= h01 * y2_q;
      p10_q <= h10 * x2_q;
      p11_q <= h11 * y2_q;
      p20_q <= h20 * x2_q;
      p21_q <= h21 * y2_q;
    end
  end

  // stage 2: numerators and denominator
  logic signed [SUMW-1:0] nx_q, ny_q, nw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= SUMW'(p00_q) + SUMW'(p01_q) + SUMW'(h02) * 2;
      ny_q <= SUMW'(p10_q) + SUMW'(p11_q) + SUMW'(h12) * 2;
      nw_q <= SUMW'(p20_q) + SUMW'(p21_q) + SUMW'(h22) * 2;
    end
  end

  // stage 3: make the divisor positive, map both floors onto nonnegative quotients
  logic signed [SW-1:0] nc, nr, dd, nw_s;
  logic                 wneg;
  logic [SW-1:0]        ac_q, ar_q, dc_q, dr_q;
  always_comb begin
    nw_s = SW'(nw_q);
    wneg = nw_s < 0;
    nc   = SW'(nx_q) * 2 + nw_s;
    nr   = nw_s - SW'(ny_q) * 2;
    dd   = nw_s * 2;
    if (wneg) begin
      nc = -nc;
      nr = -nr;
      dd = -dd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // column: floor(nc / dd) must be nonnegative
      ac_q <= nc;
      dc_q <= (nc < 0) ? '0 : dd;
      // row: offset below src_height is floor((-nr-1) / dd), needs nr < 0
      ar_q <= ~nr;
      dr_q <= (nr >= 0) ? '0 : dd;
    end
  end

  // per-axis quotient pipelines
  logic [MB-1:0] qc, qr;
  logic          okc, okr;

  hiwa_div_lane #(.AW(SW), .QW(MB)) u_div_col (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ac_q),
    .d_i   (dc_q),
    .q_o   (qc),
    .ok_o  (okc)
  );

  hiwa_div_lane #(.AW(SW), .QW(MB)) u_div_row (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ar_q),
    .d_i   (dr_q),
    .q_o   (qr),
    .ok_o  (okr)
  );

  // final: range check against the source size, output register
  logic [LW-1:0] fr;
  logic          hit;
  always_comb begin
    fr  = LW'(sh_q) - LW'(1) - LW'(qr);
    hit = okc && okr && (LW'(qc) < LW'(sw_q)) && ((LW'(qc) >> CB) == '0) &&
          (LW'(qr) < LW'(sh_q)) && ((fr >> CB) == '0);
  end

  logic [CB-1:0] src_row_q, src_col_q;
  logic          inside_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      src_row_q <= hit ? fr[CB-1:0] : '0;
      src_col_q <= hit ? qc[CB-1:0] : '0;
      inside_q  <= hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign src_row_o    = src_row_q;
  assign src_col_o    = src_col_q;
  assign inside_res_o = inside_q;

  // checks
  a_stall_only_on_back_pressure : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_q && out_stall_i))
    else $error("input stalled without output back pressure");

  a_outside_is_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |-> (src_row_o == '0 && src_col_o == '0))
    else $error("outside beat carries a nonzero address");

  a_col_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (LW'(src_col_o) < LW'(sw_q)))
    else $error("inside beat column beyond source width");

  a_row_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (LW'(src_row_o) < LW'(sh_q)))
    else $error("inside beat row beyond source height");

endmodule

@@ hw/rtl/hiwa_div_lane.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module hiwa_div_lane #(
  parameter int unsigned AW = 52,
  parameter int unsigned QW = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          ok_o
);

  logic [AW-1:0] rem_q [QW+1];
  logic [AW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ok_q  [QW+1];

  // entry stage: quotient must fit in QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= a_i;
      den_q[0] <= d_i;
      quo_q[0] <= '0;
      ok_q[0]  <= ({{QW{1'b0}}, a_i} < {d_i, {QW{1'b0}}});
    end
  end

  // one compare and subtract per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int unsigned S = QW - k;
    logic [AW+QW-1:0] dsh;
    logic             ge;
    logic [QW-1:0]    qn;
    assign dsh = {{QW{1'b0}}, den_q[k-1]} << S;
    assign ge  = ({{QW{1'b0}}, rem_q[k-1]} >= dsh);
    always_comb begin
      qn    = quo_q[k-1];
      qn[S] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_q[k-1] - dsh[AW-1:0]) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= qn;
        ok_q[k]  <= ok_q[k-1];
      end
    end
  end

  assign q_o  = quo_q[QW];
  assign ok_o = ok_q[QW];

endmodule

@@ test/tb_homography_inverse_warp_addr.sv @@
// testbench for the homography inverse warp address block, checked beat by beat
module tb_homography_inverse_warp_addr;
  import hiwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned Latency = ((CoordBits > SizeBits) ? CoordBits : SizeBits) + 6;
  localparam int unsigned IdleLimit = 4000;

  typedef struct {
    logic [CoordBits-1:0] row;
    logic [CoordBits-1:0] col;
  } pixel_t;

  typedef struct {
    logic [CoordBits-1:0] src_row;
    logic [CoordBits-1:0] src_col;
    logic                 hit;
  } addr_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [5:0]           paddr = '0;
  logic [63:0]          pwdata = '0;
  logic [63:0]          prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CoordBits-1:0] out_row_i = '0;
  logic [CoordBits-1:0] out_col_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CoordBits-1:0] src_row_o;
  logic [CoordBits-1:0] src_col_o;
  logic                 inside_res_o;

  homography_inverse_warp_addr uut (.*);

  // shadow copy of the register file
  logic [63:0]         row0_xy = 64'h0010_0000_0000_0000;
  logic [63:0]         row0c_r1x = '0;
  logic [63:0]         row1_yc = 64'h0010_0000_0000_0000;
  logic [63:0]         row2_xy = '0;
  logic [31:0]         row2_c = 32'h0010_0000;
  logic [SizeBits-1:0] src_w = SizeReset;
  logic [SizeBits-1:0] src_h = SizeReset;
  logic [SizeBits-1:0] out_h = SizeReset;

  pixel_t pixel_q[$];
  addr_t  addr_q[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     stall_mode = 0;
  int     mode_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // maps one output pixel back through the inverse homography
  function automatic addr_t map_pixel(pixel_t p);
    addr_t  a;
    longint x2, y2, nx, ny, nw, fc, fr;
    a = '{default: '0};
    x2 = 2 * longint'(p.col) - 1;
    y2 = 2 * (longint'(out_h) - longint'(p.row)) + 1;
    nx = sx32(row0_xy[63:32]) * x2 + sx32(row0_xy[31:0]) * y2 + 2 * sx32(row0c_r1x[63:32]);
    ny = sx32(row0c_r1x[31:0]) * x2 + sx32(row1_yc[63:32]) * y2 + 2 * sx32(row1_yc[31:0]);
    nw = sx32(row2_xy[63:32]) * x2 + sx32(row2_xy[31:0]) * y2 + 2 * sx32(row2_c);
    if (nw == 0) return a;
    fc = floor_quot(2 * nx + nw, 2 * nw);
    fr = longint'(src_h) + floor_quot(nw - 2 * ny, 2 * nw);
    if (fc >= 0 && fc < longint'(src_w) && fc < (1 << CoordBits) &&
        fr >= 0 && fr < longint'(src_h) && fr < (1 << CoordBits)) begin
      a.src_row = fr[CoordBits-1:0];
      a.src_col = fc[CoordBits-1:0];
      a.hit = 1'b1;
    end
    return a;
  endfunction

  // input side: bursts with random gaps, prediction taken at acceptance
  always @(posedge clk_i) begin : drive
    bit advance;
    advance = !in_valid_i || !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      addr_q.insert(addr_q.size(), map_pixel('{row: out_row_i, col: out_col_i}));
      void'(pixel_q.pop_front());
    end
    if (advance) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_valid_i <= 1'b1;
        out_row_i <= pixel_q[0].row;
        out_col_i <= pixel_q[0].col;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: free running, random stalls, or long stall blocks
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(32, 400);
      stall_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(1, 50);
          out_stall_i <= !out_stall_i;
        end else begin
          stall_left--;
        end
      end
    endcase
  end

  // compare each result beat with the oldest predicted address
  always @(posedge clk_i) begin : watch
    addr_t e;
    if (out_valid_o && !out_stall_i) begin
      if (addr_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: row %0d col %0d inside %0b",
                   src_row_o, src_col_o, inside_res_o);
      end else begin
        e = addr_q.pop_front();
        if (e.src_row !== src_row_o || e.src_col !== src_col_o ||
            e.hit !== inside_res_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp row %0d col %0d inside %0b,",
                      " got row %0d col %0d inside %0b"},
                     e.src_row, e.src_col, e.hit, src_row_o, src_col_o, inside_res_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat while work is pending
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pixel_q.size() == 0 && addr_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(cfg_idx_e idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_ROW0_XY:   row0_xy = val;
      CFG_ROW0C_R1X: row0c_r1x = val;
      CFG_ROW1_YC:   row1_yc = val;
      CFG_ROW2_XY:   row2_xy = val;
      CFG_ROW2_C:    row2_c = val[31:0];
      CFG_SRC_W:     src_w = val[SizeBits-1:0];
      CFG_SRC_H:     src_h = val[SizeBits-1:0];
      default:       out_h = val[SizeBits-1:0];
    endcase
  endtask

  task automatic set_matrix(longint h[9]);
    reg_write(CFG_ROW0_XY, {h[0][31:0], h[1][31:0]});
    reg_write(CFG_ROW0C_R1X, {h[2][31:0], h[3][31:0]});
    reg_write(CFG_ROW1_YC, {h[4][31:0], h[5][31:0]});
    reg_write(CFG_ROW2_XY, {h[6][31:0], h[7][31:0]});
    reg_write(CFG_ROW2_C, {32'd0, h[8][31:0]});
  endtask

  task automatic set_sizes(int w, int hgt, int oh);
    reg_write(CFG_SRC_W, 64'(w));
    reg_write(CFG_SRC_H, 64'(hgt));
    reg_write(CFG_OUT_H, 64'(oh));
  endtask

  function automatic longint rnd_s(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  // mostly raster runs like a real frame scan, the rest scattered pixels
  task automatic queue_pixels(int n);
    pixel_t p;
    int     run;
    while (n > 0) begin
      if ($urandom_range(0, 9) < 6) begin
        p.row = CoordBits'($urandom);
        p.col = CoordBits'($urandom);
        run = $urandom_range(1, 30);
        for (int i = 0; i < run && n > 0; i++) begin
          pixel_q.insert(pixel_q.size(), p);
          p.col = p.col + 1'b1;
          n--;
        end
      end else begin
        p.row = CoordBits'($urandom);
        p.col = CoordBits'($urandom);
        pixel_q.insert(pixel_q.size(), p);
        n--;
      end
    end
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || addr_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
  endtask

  localparam longint One = 1 << 20;

  initial begin
    longint h[9];
    longint s;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners and edges at the reset identity mapping
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pixel_q.insert(pixel_q.size(), '{row: (r == 3) ? 12'd4095 : 12'(r * 1365),
                                         col: (c == 3) ? 12'd4095 : 12'(c)});
      end
    end
    pixel_q.insert(pixel_q.size(), '{row: 12'd1, col: 12'd1});
    pixel_q.insert(pixel_q.size(), '{row: 12'd2048, col: 12'd2048});
    pixel_q.insert(pixel_q.size(), '{row: 12'haaa, col: 12'h555});
    pixel_q.insert(pixel_q.size(), '{row: 12'h555, col: 12'haaa});
    drain();

    // identity with the smallest sizes
    set_sizes(1, 1, 1);
    queue_pixels(60);
    pixel_q.insert(pixel_q.size(), '{row: 12'd0, col: 12'd0});
    pixel_q.insert(pixel_q.size(), '{row: 12'd0, col: 12'd1});
    pixel_q.insert(pixel_q.size(), '{row: 12'd1, col: 12'd0});
    drain();

    // random affine and projective mappings with mostly in-range sources
    for (int ph = 0; ph < 5; ph++) begin
      h[0] = rnd_s(2 * One);
      h[1] = rnd_s(One / 2);
      h[2] = rnd_s(2000 * One);
      h[3] = rnd_s(One / 2);
      h[4] = rnd_s(2 * One);
      h[5] = rnd_s(2000 * One);
      h[6] = (ph < 2) ? 0 : rnd_s(256);
      h[7] = (ph < 2) ? 0 : rnd_s(256);
      h[8] = One;
      s = $urandom_range(1, 3);
      if (ph == 4) s = -1;
      for (int i = 0; i < 9; i++) h[i] = h[i] * s;
      set_matrix(h);
      set_sizes($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096));
      queue_pixels(240);
      drain();
    end

    // extreme coefficients and sizes beyond the nominal range
    h = '{64'h7fff_ffff, 64'h8000_0000, 64'h7fff_ffff, 64'h8000_0000, 64'h7fff_ffff,
          64'h8000_0000, rnd_s(4096), rnd_s(4096), 64'h8000_0000};
    set_matrix(h);
    set_sizes(8191, 8191, 8191);
    queue_pixels(200);
    drain();

    // denominator zero everywhere
    h = '{One, 0, 0, 0, One, 0, 0, 0, 0};
    set_matrix(h);
    set_sizes(4096, 4096, 4096);
    queue_pixels(100);
    drain();

    // denominator zero along a diagonal, zero width never hits
    h = '{One, 0, 0, 0, One, 0, One, One, 0};
    set_matrix(h);
    set_sizes(0, 4096, 16);
    queue_pixels(100);
    for (int i = 0; i < 10; i++)
      pixel_q.insert(pixel_q.size(), '{row: 12'(i + 16), col: 12'(i)});
    drain();
    set_sizes(4096, 0, 16);
    queue_pixels(100);
    drain();

    // mild perspective over the full canvas
    h = '{One, rnd_s(One / 64), rnd_s(100 * One), rnd_s(One / 64), One, rnd_s(100 * One),
          rnd_s(64), rnd_s(64), One};
    set_matrix(h);
    set_sizes(4096, 4096, 4096);
    queue_pixels(260);
    drain();

    if (mismatches == 0 && addr_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
